@@ sv/url_path_segment_decoder_defines.svh @@
// Assertion macros shared by the path segment decoder modules.
// No dependencies; included by the files that carry assertions.
`ifndef URL_PATH_SEGMENT_DECODER_DEFINES_SVH
`define URL_PATH_SEGMENT_DECODER_DEFINES_SVH

// Check on every rising edge of clk_i outside reset.
`define UPSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define UPSD_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/upsd_pkg.sv @@
// Package for the URL path segment decoder: characters, scan modes, result types.
// Hex helper functions. No dependencies.
`timescale 1ns / 1ps

package upsd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChQuery   = 8'h3F;

  // Fixed slot order per input word: broken '%', held digit, main result,
  // end-of-target '%', end-of-target held digit, final mark.
  localparam int unsigned NumSlots   = 6;
  localparam int unsigned MaxResults = 4;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModePct    = 2'd1,
    ModePctHex = 2'd2
  } upsd_mode_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       segment_end;
    logic       final_res;
  } upsd_res_t;

  typedef struct packed {
    logic [NumSlots-1:0]            mask;
    upsd_res_t [NumSlots-1:0]       slot;
  } upsd_burst_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage

@@ sv/upsd_intf.sv @@
// Valid/ready stream interfaces for the input and result channels.
// No dependencies.
`timescale 1ns / 1ps

interface upsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, in_byte, is_last, input ready);
  modport sink (input valid, in_byte, is_last, output ready);
endinterface

interface upsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       segment_end;
  logic       final_res;

  modport source (output valid, out_byte, byte_valid, segment_end, final_res, input ready);
  modport sink (input valid, out_byte, byte_valid, segment_end, final_res, output ready);
endinterface

@@ sv/url_path_segment_decoder.sv @@
// Channel    Dir  Payload                                          Handshake
// in_i       in   in_byte[8], is_last                               valid/ready
// out_o      out  out_byte[8], byte_valid, segment_end, final_res   valid/ready
//
// Each byte is held in the input register, then its results (zero to four words)
// sit in the result buffer and leave at one word per cycle while out_o is ready.
// A byte that yields at most one word sustains one byte per cycle while out_o is ready;
// a byte yielding more words holds the input until the buffer is down to its last word.
// Reset clears the scan state and both buffers; stalls on out_o back up into in_i.
// Depends on upsd_pkg, upsd_intf, upsd_decode and upsd_out_seq.
`timescale 1ns / 1ps

module url_path_segment_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  upsd_in_if.sink    in_i,
  upsd_out_if.source out_o
);

  upsd_pkg::upsd_burst_t burst;
  logic                  burst_vld;
  logic                  load_ok;

  upsd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .load_ok_i   (load_ok),
    .burst_vld_o (burst_vld),
    .burst_o     (burst)
  );

  upsd_out_seq u_out_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_vld_i (burst_vld),
    .burst_i     (burst),
    .load_ok_o   (load_ok),
    .out_o       (out_o)
  );

endmodule

@@ sv/upsd_decode.sv @@
// Input register, scan state and single-pass decode of one word into a result burst.
// Depends on upsd_pkg, upsd_intf and the shared assertion macros.
`timescale 1ns / 1ps
`include "url_path_segment_decoder_defines.svh"

module upsd_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  upsd_in_if.sink              in_i,
  input  logic                 load_ok_i,
  output logic                 burst_vld_o,
  output upsd_pkg::upsd_burst_t burst_o
);

  logic                 in_vld_q, in_vld_d;
  logic [7:0]           in_byte_q, in_byte_d;
  logic                 in_last_q, in_last_d;
  upsd_pkg::upsd_mode_e mode_q, mode_d;
  logic [7:0]           held_q, held_d;
  logic                 at_start_q, at_start_d;
  logic                 skip_q, skip_d;

  upsd_pkg::upsd_mode_e cur_mode, mid_mode;
  logic [7:0]           mid_held;
  logic                 take, live, b_query, b_slash, b_pct, b_hex;
  logic                 pct_hi, pct_dec, normal_take, flush_a;

  assign take        = in_vld_q && load_ok_i;
  assign in_i.ready  = !in_vld_q || take;
  assign burst_vld_o = in_vld_q;

  always_comb begin
    case (mode_q)
      upsd_pkg::ModePct:    cur_mode = upsd_pkg::ModePct;
      upsd_pkg::ModePctHex: cur_mode = upsd_pkg::ModePctHex;
      default:              cur_mode = upsd_pkg::ModeNormal;
    endcase
  end

  assign live        = !skip_q;
  assign b_query     = in_byte_q == upsd_pkg::ChQuery;
  assign b_slash     = in_byte_q == upsd_pkg::ChSlash;
  assign b_pct       = in_byte_q == upsd_pkg::ChPercent;
  assign b_hex       = upsd_pkg::is_hex(in_byte_q);
  assign pct_hi      = live && !b_query && cur_mode == upsd_pkg::ModePct && b_hex;
  assign pct_dec     = live && !b_query && cur_mode == upsd_pkg::ModePctHex && b_hex;
  assign normal_take = live && !b_query && !pct_hi && !pct_dec;
  assign flush_a     = live && (b_query || normal_take) && cur_mode != upsd_pkg::ModeNormal;

  always_comb begin
    if (pct_hi) begin
      mid_mode = upsd_pkg::ModePctHex;
    end else if (normal_take && b_pct) begin
      mid_mode = upsd_pkg::ModePct;
    end else begin
      mid_mode = upsd_pkg::ModeNormal;
    end
    mid_held = pct_hi ? in_byte_q : 8'h00;
  end

  // Next state
  always_comb begin
    in_vld_d   = in_vld_q;
    in_byte_d  = in_byte_q;
    in_last_d  = in_last_q;
    mode_d     = mode_q;
    held_d     = held_q;
    at_start_d = at_start_q;
    skip_d     = skip_q;
    if (take) begin
      in_vld_d = 1'b0;
      if (in_last_q) begin
        mode_d     = upsd_pkg::ModeNormal;
        held_d     = 8'h00;
        at_start_d = 1'b1;
        skip_d     = 1'b0;
      end else begin
        mode_d     = mid_mode;
        held_d     = mid_held;
        at_start_d = live ? 1'b0 : at_start_q;
        skip_d     = skip_q || b_query;
      end
    end
    if (in_i.valid && in_i.ready) begin
      in_vld_d  = 1'b1;
      in_byte_d = in_i.in_byte;
      in_last_d = in_i.is_last;
    end
  end

  // Burst outputs
  always_comb begin
    burst_o = '0;

    burst_o.mask[0]            = flush_a;
    burst_o.slot[0].out_byte   = upsd_pkg::ChPercent;
    burst_o.slot[0].byte_valid = 1'b1;

    burst_o.mask[1]            = flush_a && cur_mode == upsd_pkg::ModePctHex;
    burst_o.slot[1].out_byte   = held_q;
    burst_o.slot[1].byte_valid = 1'b1;

    if (pct_dec) begin
      burst_o.mask[2]            = 1'b1;
      burst_o.slot[2].out_byte   = {upsd_pkg::hex_val(held_q), upsd_pkg::hex_val(in_byte_q)};
      burst_o.slot[2].byte_valid = 1'b1;
    end else if (normal_take && b_slash) begin
      burst_o.mask[2]             = !at_start_q;
      burst_o.slot[2].segment_end = 1'b1;
    end else if (normal_take && !b_pct) begin
      burst_o.mask[2]            = 1'b1;
      burst_o.slot[2].out_byte   = in_byte_q;
      burst_o.slot[2].byte_valid = 1'b1;
    end

    burst_o.mask[3]            = in_last_q && mid_mode != upsd_pkg::ModeNormal;
    burst_o.slot[3].out_byte   = upsd_pkg::ChPercent;
    burst_o.slot[3].byte_valid = 1'b1;

    burst_o.mask[4]            = in_last_q && mid_mode == upsd_pkg::ModePctHex;
    burst_o.slot[4].out_byte   = mid_held;
    burst_o.slot[4].byte_valid = 1'b1;

    burst_o.mask[5]              = in_last_q;
    burst_o.slot[5].segment_end  = 1'b1;
    burst_o.slot[5].final_res    = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      mode_q     <= upsd_pkg::ModeNormal;
      held_q     <= 8'h00;
      at_start_q <= 1'b1;
      skip_q     <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_d;
      mode_q     <= mode_d;
      held_q     <= held_d;
      at_start_q <= at_start_d;
      skip_q     <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_last_q <= in_last_d;
  end

  `UPSD_ASSERT(a_last_restarts, take && in_last_q |=> at_start_q && !skip_q && mode_q == upsd_pkg::ModeNormal, "target end did not restore scan state")
  `UPSD_ASSERT(a_skip_normal, skip_q |-> mode_q == upsd_pkg::ModeNormal && held_q == 8'h00, "escape pending while skipping query")
  `UPSD_ASSERT(a_held_hex, mode_q == upsd_pkg::ModePctHex |-> upsd_pkg::is_hex(held_q), "held escape digit is not hex")

endmodule

@@ sv/upsd_out_seq.sv @@
// Result buffer: holds one burst of slots and hands them out one word per cycle while out_o is ready.
// Depends on upsd_pkg, upsd_intf and the shared assertion macros.
`timescale 1ns / 1ps
`include "url_path_segment_decoder_defines.svh"

module upsd_out_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  burst_vld_i,
  input  upsd_pkg::upsd_burst_t burst_i,
  output logic                  load_ok_o,
  upsd_out_if.source            out_o
);

  logic [upsd_pkg::NumSlots-1:0]           mask_q, mask_d, mask_rest;
  upsd_pkg::upsd_res_t [upsd_pkg::NumSlots-1:0] slot_q;
  upsd_pkg::upsd_res_t                     cur;
  logic                                    load, sent;

  assign mask_rest = mask_q & (mask_q - upsd_pkg::NumSlots'(1));
  assign sent      = out_o.valid && out_o.ready;
  assign load_ok_o = (mask_rest == '0) && ((mask_q == '0) || out_o.ready);
  assign load      = burst_vld_i && load_ok_o;

  // Lowest pending slot goes out first
  always_comb begin
    cur = '0;
    for (int i = upsd_pkg::NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        cur = slot_q[i];
      end
    end
  end

  assign out_o.valid       = mask_q != '0;
  assign out_o.out_byte    = cur.out_byte;
  assign out_o.byte_valid  = cur.byte_valid;
  assign out_o.segment_end = cur.segment_end;
  assign out_o.final_res   = cur.final_res;

  always_comb begin
    mask_d = mask_q;
    if (sent) begin
      mask_d = mask_rest;
    end
    if (load) begin
      mask_d = burst_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q <= burst_i.slot;
    end
  end

  `UPSD_ASSERT_NORST(a_reset_empty, !rst_ni |=> mask_q == '0, "result buffer not empty after reset")
  `UPSD_ASSERT(a_burst_size, $countones(mask_q) <= upsd_pkg::MaxResults, "burst longer than four words")
  `UPSD_ASSERT(a_stall_hold, (mask_q != '0) && !out_o.ready |=> mask_q == $past(mask_q), "pending words changed under stall")
  `UPSD_ASSERT(a_final_alone, out_o.valid && out_o.final_res |-> $countones(mask_q) == 1 && out_o.segment_end && !out_o.byte_valid, "final mark not a lone segment end")

endmodule

@@ sim/upsd_checker.sv @@
// Result checker for the URL path segment decoder: predicts each result word from the
// accepted input words and compares it with what leaves the block.
// Depends on upsd_pkg and upsd_intf.
`timescale 1ns / 1ps

module upsd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  upsd_in_if   in_mon,
  upsd_out_if  out_mon,
  output int   pending_o,
  output int   errors_o
);

  upsd_pkg::upsd_res_t  seg_words_q[$];
  upsd_pkg::upsd_mode_e esc_mode;
  logic [7:0]           held_digit;
  logic                 at_start;
  logic                 in_query;
  int                   err_cnt;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      return {1'b1, 4'(c - "a" + 10)};
    end else if (c >= "A" && c <= "F") begin
      return {1'b1, 4'(c - "A" + 10)};
    end
    return 5'd0;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic bv, input logic se,
                           input logic fin);
    upsd_pkg::upsd_res_t w;
    w.out_byte    = b;
    w.byte_valid  = bv;
    w.segment_end = se;
    w.final_res   = fin;
    seg_words_q = {seg_words_q, w};
  endtask

  task automatic clear_scan();
    esc_mode   = upsd_pkg::ModeNormal;
    held_digit = 8'h00;
    at_start   = 1'b1;
    in_query   = 1'b0;
  endtask

  // Emit a partial escape literally.
  task automatic flush_escape();
    if (esc_mode == upsd_pkg::ModePct) begin
      push_word(upsd_pkg::ChPercent, 1'b1, 1'b0, 1'b0);
    end else if (esc_mode == upsd_pkg::ModePctHex) begin
      push_word(upsd_pkg::ChPercent, 1'b1, 1'b0, 1'b0);
      push_word(held_digit, 1'b1, 1'b0, 1'b0);
    end
    esc_mode   = upsd_pkg::ModeNormal;
    held_digit = 8'h00;
  endtask

  task automatic take_path_byte(input logic [7:0] b, input logic first);
    if (b == upsd_pkg::ChSlash) begin
      if (!first) begin
        push_word(8'h00, 1'b0, 1'b1, 1'b0);
      end
    end else if (b == upsd_pkg::ChPercent) begin
      esc_mode = upsd_pkg::ModePct;
    end else begin
      push_word(b, 1'b1, 1'b0, 1'b0);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic       first;
    logic [4:0] hi;
    logic [4:0] lo;
    first = at_start;
    lo    = nibble_of(b);
    if (!in_query) begin
      at_start = 1'b0;
      if (b == upsd_pkg::ChQuery) begin
        flush_escape();
        in_query = 1'b1;
      end else if (esc_mode == upsd_pkg::ModePct) begin
        if (lo[4]) begin
          held_digit = b;
          esc_mode   = upsd_pkg::ModePctHex;
        end else begin
          flush_escape();
          take_path_byte(b, first);
        end
      end else if (esc_mode == upsd_pkg::ModePctHex) begin
        if (lo[4]) begin
          hi = nibble_of(held_digit);
          push_word({hi[3:0], lo[3:0]}, 1'b1, 1'b0, 1'b0);
          esc_mode   = upsd_pkg::ModeNormal;
          held_digit = 8'h00;
        end else begin
          flush_escape();
          take_path_byte(b, first);
        end
      end else begin
        take_path_byte(b, first);
      end
    end
    if (last) begin
      flush_escape();
      push_word(8'h00, 1'b0, 1'b1, 1'b1);
      clear_scan();
    end
  endtask

  task automatic report(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t upsd_checker: %s expected %0h got %0h", $time, field, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    upsd_pkg::upsd_res_t want;
    if (!rst_ni) begin
      clear_scan();
      seg_words_q.delete();
      err_cnt   = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.in_byte, in_mon.is_last);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (seg_words_q.size() == 0) begin
          $display("%0t upsd_checker: word with none expected, got %0h/%b/%b/%b", $time,
                   out_mon.out_byte, out_mon.byte_valid, out_mon.segment_end,
                   out_mon.final_res);
          err_cnt++;
        end else begin
          want = seg_words_q.pop_front();
          report("out_byte", want.out_byte, out_mon.out_byte);
          report("byte_valid", want.byte_valid, out_mon.byte_valid);
          report("segment_end", want.segment_end, out_mon.segment_end);
          report("final_res", want.final_res, out_mon.final_res);
        end
      end
      pending_o <= seg_words_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Top of the URL path segment decoder testbench: clock, reset, request target stimulus,
// random stalls on both channels, watchdog and verdict.
// Depends on upsd_pkg, upsd_intf, url_path_segment_decoder and upsd_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int TargetBytes = 320;
  localparam int QuietLimit  = 2000;
  localparam int IdlePct     = 38;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       steady;
  int         pending;
  int         mismatches;
  int         quiet_cycles;
  int         sent;
  logic [7:0] target_q[$];

  upsd_in_if  in_if ();
  upsd_out_if out_if ();

  url_path_segment_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  upsd_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .pending_o (pending),
    .errors_o  (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    if (!steady) begin
      while ($urandom_range(99) < IdlePct) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.is_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_text(input string s, input logic closes);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], closes && (i == s.len() - 1));
    end
  endtask

  // Hold the input until every expected word has left.
  task automatic wait_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  task automatic add_byte(input logic [7:0] b);
    target_q = {target_q, b};
  endtask

  task automatic make_target();
    int n;
    int pick;
    target_q.delete();
    n = $urandom_range(12, 1);
    if ($urandom_range(9) == 0) begin
      repeat (n) add_byte(8'($urandom_range(255)));
    end else begin
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          add_byte(upsd_pkg::ChPercent);
          add_byte(hex_char());
          add_byte(hex_char());
        end else if (pick < 42) begin
          add_byte(upsd_pkg::ChSlash);
        end else if (pick < 47) begin
          add_byte(upsd_pkg::ChQuery);
        end else if (pick < 57) begin
          add_byte(upsd_pkg::ChPercent);
          if ($urandom_range(1)) begin
            add_byte(hex_char());
          end
        end else begin
          add_byte(8'($urandom_range(255)));
        end
      end
    end
  endtask

  task automatic send_target();
    foreach (target_q[i]) begin
      push_byte(target_q[i], i == target_q.size() - 1);
    end
  endtask

  initial begin
    logic paused;
    paused = 1'b0;
    sent   = 0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    in_if.is_last <= 1'b0;
    steady        <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_text("/", 1'b1);
    send_text("/%4a%6F/", 1'b1);
    send_text("%g%4z%%41", 1'b1);
    send_text("%4?", 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(upsd_pkg::ChPercent, 1'b1);
    wait_results();

    while (sent < TargetBytes) begin
      steady <= (sent >= 130 && sent < 210);
      if (!paused && sent >= 220) begin
        wait_results();
        paused = 1'b1;
      end
      make_target();
      send_target();
    end

    steady <= 1'b0;
    wait_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
